>>> hdl/sith_pkg.sv
// Package for the symbol intern hash table: sizes, result status codes,
// controller states, the hash unit's control structs and the PJW step and fold functions.
// Depends on nothing; every other file but sith_ram imports it.
package sith_pkg;

    localparam int TABLE_SIZE   = 2029;
    localparam int MAX_NAME_LEN = 32;
    localparam int HASH_W       = 32;
    localparam int BYTE_W       = 8;
    localparam int IDX_W        = $clog2(TABLE_SIZE);
    localparam int LEN_W        = $clog2(MAX_NAME_LEN + 1);
    localparam int NAME_AW      = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
    localparam int CHAR_DEPTH   = TABLE_SIZE * MAX_NAME_LEN;
    localparam int CHAR_AW      = $clog2(CHAR_DEPTH);
    localparam int PROBE_W      = $clog2(TABLE_SIZE + 1);
    localparam int STATUS_W     = 2;
    // Remainder of 2**IDX_W modulo the table size.
    localparam int FOLD_MUL     = (1 << IDX_W) - TABLE_SIZE;

    localparam logic [HASH_W-1:0] TOP_NIBBLE = 32'hF000_0000;

    typedef enum logic [STATUS_W-1:0] {
        STAT_FOUND    = 2'd0,
        STAT_INSERTED = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_TOO_LONG = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_LEN_RD,
        ST_LEN_CHK,
        ST_CMP_RD,
        ST_CMP_CHK,
        ST_INS_RD,
        ST_INS_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              feed;
        logic              twice;
        logic              clear;
        logic [BYTE_W-1:0] data;
    } hash_ctrl_t;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] start_idx;
    } hash_stat_t;

    function automatic logic [HASH_W-1:0] pjw_feed(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] c);
        logic [HASH_W-1:0] x;
        logic [HASH_W-1:0] top;
        x   = (h << 4) + HASH_W'(c);
        top = x & TOP_NIBBLE;
        if (top != '0)
        begin
            x = x ^ (top | (top >> 24));
        end
        return x;
    endfunction

    // Folds the bits above IDX_W back onto the low bits; the result is congruent
    // to the input modulo the table size and strictly smaller when any high bit is set.
    function automatic logic [HASH_W-1:0] fold_high(input logic [HASH_W-1:0] h);
        return (h >> IDX_W) * HASH_W'(FOLD_MUL) + HASH_W'(h[IDX_W-1:0]);
    endfunction

endpackage

>>> hdl/sith_in_if.sv
// Input channel of the symbol intern hash table: one name byte per transfer.
// Depends on sith_pkg for the byte width.
interface sith_in_if
    import sith_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] name_byte;
    logic              last_byte;

    modport source (output valid, output name_byte, output last_byte, input ready);
    modport sink   (input valid, input name_byte, input last_byte, output ready);
endinterface

>>> hdl/sith_out_if.sv
// Result channel of the symbol intern hash table: bucket index and status.
// Depends on sith_pkg for the index and status widths.
interface sith_out_if
    import sith_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    bucket_index;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output bucket_index, output status, input ready);
    modport sink   (input valid, input bucket_index, input status, output ready);
endinterface

>>> hdl/sith_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; used for the name buffer and both bucket stores.
module sith_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> hdl/sith_hash.sv
// PJW hash accumulator and folding modulo-TABLE_SIZE reduction unit.
// Depends on sith_pkg (pjw_feed, fold_high, hash_ctrl_t, hash_stat_t).
module sith_hash
    import sith_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  hash_ctrl_t ctrl,
    output hash_stat_t stat
);
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [IDX_W-1:0]  rem_reg, rem_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [HASH_W-1:0] fed;
    logic [IDX_W-1:0]  low_part;

    // The finished hash is reduced in place, one fold per cycle, until it fits
    // in IDX_W bits. It is then below twice the table size, so one compare and
    // subtract completes the remainder. A 32-bit hash needs at most five folds.
    always_comb
    begin
        hash_next = hash_reg;
        rem_next  = rem_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        fed       = pjw_feed(hash_reg, ctrl.data);
        low_part  = hash_reg[IDX_W-1:0];
        if (ctrl.clear)
        begin
            hash_next = '0;
        end
        else if (ctrl.feed)
        begin
            if (ctrl.twice)
            begin
                hash_next = pjw_feed(fed, ctrl.data);
                busy_next = 1'b1;
            end
            else
            begin
                hash_next = fed;
            end
        end
        else if (busy_reg)
        begin
            if (hash_reg[HASH_W-1:IDX_W] != '0)
            begin
                hash_next = fold_high(hash_reg);
            end
            else
            begin
                if (low_part >= IDX_W'(TABLE_SIZE))
                begin
                    rem_next = low_part - IDX_W'(TABLE_SIZE);
                end
                else
                begin
                    rem_next = low_part;
                end
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            hash_reg <= hash_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    assign stat.done      = done_reg;
    assign stat.start_idx = rem_reg;
endmodule

>>> hdl/symbol_intern_hash_table.sv
// Bytes are taken one per cycle while names.ready is high; after the final byte the hash
// is reduced modulo the table size, each probed bucket is read and then checked, each
// compared or copied byte is read and then checked or written, and the result is registered.
// One name at a time: input is held off from the final byte until the result
// is loaded. Reset: asynchronous, active low; a pass over every bucket then
// clears the bucket length store, during which names.ready stays low.
module symbol_intern_hash_table
    import sith_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sith_in_if.sink     names,
    sith_out_if.source  results
);
    // Controller registers.
    state_t               state_reg, state_next;
    logic [LEN_W-1:0]     count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     clr_reg, clr_next;
    logic [PROBE_W-1:0]   probe_reg, probe_next;
    logic [LEN_W-1:0]     k_reg, k_next;
    logic [IDX_W-1:0]     res_idx_reg, res_idx_next;
    status_t              res_stat_reg, res_stat_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     out_idx_reg, out_idx_next;
    status_t              out_stat_reg, out_stat_next;

    // Handshake and memory controls.
    logic                 accept;
    logic                 buffered;
    logic                 load_out;
    logic                 name_we;
    logic [BYTE_W-1:0]    name_rdata;
    logic                 len_we;
    logic [IDX_W-1:0]     len_waddr;
    logic [LEN_W-1:0]     len_wdata;
    logic [LEN_W-1:0]     len_rdata;
    logic                 char_we;
    logic [CHAR_AW-1:0]   char_addr;
    logic [BYTE_W-1:0]    char_rdata;
    logic                 last_k;
    logic [IDX_W-1:0]     idx_inc;
    logic                 sweep_done;
    hash_ctrl_t           hctrl;
    hash_stat_t           hstat;

    assign names.ready = (state_reg == ST_IDLE);
    assign accept      = names.valid && names.ready;
    // Bytes beyond the buffer are dropped and only mark the name as too long.
    assign buffered    = (count_reg < LEN_W'(MAX_NAME_LEN));
    assign load_out    = (state_reg == ST_DONE) && (!out_valid_reg || results.ready);
    assign last_k      = (k_reg == count_reg - 1'b1);
    assign idx_inc     = (idx_reg == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_reg + 1'b1;
    // A complete sweep has visited every bucket once.
    assign sweep_done  = ((probe_reg + 1'b1) == PROBE_W'(TABLE_SIZE));
    assign char_addr   = CHAR_AW'(idx_reg) * CHAR_AW'(MAX_NAME_LEN) + CHAR_AW'(k_reg);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == IDX_W'(TABLE_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && names.last_byte)
                begin
                    state_next = (buffered && !ovf_reg) ? ST_HASH : ST_DONE;
                end
            end
            ST_HASH:
            begin
                if (hstat.done)
                begin
                    state_next = ST_LEN_RD;
                end
            end
            ST_LEN_RD:
            begin
                state_next = ST_LEN_CHK;
            end
            ST_LEN_CHK:
            begin
                if (len_rdata == '0)
                begin
                    state_next = ST_INS_RD;
                end
                else if (len_rdata == count_reg)
                begin
                    state_next = ST_CMP_RD;
                end
                else
                begin
                    state_next = sweep_done ? ST_DONE : ST_LEN_RD;
                end
            end
            ST_CMP_RD:
            begin
                state_next = ST_CMP_CHK;
            end
            ST_CMP_CHK:
            begin
                if (name_rdata != char_rdata)
                begin
                    state_next = sweep_done ? ST_DONE : ST_LEN_RD;
                end
                else
                begin
                    state_next = last_k ? ST_DONE : ST_CMP_RD;
                end
            end
            ST_INS_RD:
            begin
                state_next = ST_INS_WR;
            end
            ST_INS_WR:
            begin
                state_next = last_k ? ST_DONE : ST_INS_RD;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory and hash unit controls, decoded from the state.
    always_comb
    begin
        name_we     = 1'b0;
        len_we      = 1'b0;
        len_waddr   = idx_reg;
        len_wdata   = count_reg;
        char_we     = 1'b0;
        hctrl.feed  = 1'b0;
        hctrl.twice = 1'b0;
        hctrl.clear = 1'b0;
        hctrl.data  = names.name_byte;
        case (state_reg)
            ST_CLEAR:
            begin
                len_we    = 1'b1;
                len_waddr = clr_reg;
                len_wdata = '0;
            end
            ST_IDLE:
            begin
                name_we     = accept && buffered;
                hctrl.feed  = accept && buffered;
                // The final byte goes through the hash a second time.
                hctrl.twice = accept && buffered && names.last_byte;
            end
            ST_LEN_CHK:
            begin
                len_we = (len_rdata == '0);
            end
            ST_INS_WR:
            begin
                char_we = 1'b1;
            end
            ST_DONE:
            begin
                hctrl.clear = load_out;
            end
            default:
            begin
                name_we = 1'b0;
            end
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        clr_next       = clr_reg;
        probe_next     = probe_reg;
        k_next         = k_reg;
        res_idx_next   = res_idx_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_stat_next  = out_stat_reg;

        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (buffered)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (names.last_byte)
                    begin
                        res_idx_next  = '0;
                        res_stat_next = STAT_TOO_LONG;
                    end
                end
            end
            ST_HASH:
            begin
                idx_next   = hstat.start_idx;
                probe_next = '0;
            end
            ST_LEN_CHK:
            begin
                k_next = '0;
                if (len_rdata == '0)
                begin
                    res_idx_next  = idx_reg;
                    res_stat_next = STAT_INSERTED;
                end
                else if (len_rdata != count_reg)
                begin
                    idx_next      = idx_inc;
                    probe_next    = probe_reg + 1'b1;
                    res_idx_next  = '0;
                    res_stat_next = STAT_FULL;
                end
            end
            ST_CMP_CHK:
            begin
                if (name_rdata != char_rdata)
                begin
                    idx_next      = idx_inc;
                    probe_next    = probe_reg + 1'b1;
                    res_idx_next  = '0;
                    res_stat_next = STAT_FULL;
                end
                else if (last_k)
                begin
                    res_idx_next  = idx_reg;
                    res_stat_next = STAT_FOUND;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_INS_WR:
            begin
                k_next = k_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = res_idx_reg;
                    out_stat_next  = res_stat_reg;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                end
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        probe_reg    <= probe_next;
        k_reg        <= k_next;
        res_idx_reg  <= res_idx_next;
        res_stat_reg <= res_stat_next;
        out_idx_reg  <= out_idx_next;
        out_stat_reg <= out_stat_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.bucket_index = out_idx_reg;
    assign results.status       = out_stat_reg;

    // Buffer for the name being received; read back byte by byte while
    // comparing or copying it into a bucket.
    sith_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_NAME_LEN)
    ) u_name_ram (
        .clk   (clk),
        .we    (name_we),
        .waddr (count_reg[NAME_AW-1:0]),
        .wdata (names.name_byte),
        .raddr (k_reg[NAME_AW-1:0]),
        .rdata (name_rdata)
    );

    // Stored length per bucket; zero marks an empty bucket.
    sith_ram #(
        .WIDTH (LEN_W),
        .DEPTH (TABLE_SIZE)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .raddr (idx_reg),
        .rdata (len_rdata)
    );

    // Stored name bytes, MAX_NAME_LEN slots per bucket.
    sith_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CHAR_DEPTH)
    ) u_char_ram (
        .clk   (clk),
        .we    (char_we),
        .waddr (char_addr),
        .wdata (name_rdata),
        .raddr (char_addr),
        .rdata (char_rdata)
    );

    sith_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (hctrl),
        .stat  (hstat)
    );
endmodule

>>> hdl/sith_checker.sv
// Port-level checks for the symbol intern hash table, and the bind that
// attaches them to the top level. Depends on sith_pkg.
module sith_checker
    import sith_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                names_valid,
    input logic                names_ready,
    input logic                names_last_byte,
    input logic                results_valid,
    input logic                results_ready,
    input logic [IDX_W-1:0]    bucket_index,
    input logic [STATUS_W-1:0] status
);
    // A result offered and not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && !results_ready |=> results_valid)
    else $error("result withdrawn before its transfer");

    // Every reported bucket lies inside the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        results_valid |-> (bucket_index < IDX_W'(TABLE_SIZE)))
    else $error("bucket index beyond the table");

    // A full table or an overlong name reports bucket zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && (status == STAT_FULL || status == STAT_TOO_LONG)
        |-> (bucket_index == '0))
    else $error("non-zero bucket with a failure status");

    // The end of a name starts a lookup or a too-long result, so no byte is taken in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        names_valid && names_ready && names_last_byte |=> !names_ready)
    else $error("byte taken straight after the end of a name");
endmodule

bind symbol_intern_hash_table sith_checker u_sith_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .names_valid     (names.valid),
    .names_ready     (names.ready),
    .names_last_byte (names.last_byte),
    .results_valid   (results.valid),
    .results_ready   (results.ready),
    .bucket_index    (results.bucket_index),
    .status          (results.status)
);

>>> tb/tb_symbol_intern_hash_table.sv
`timescale 1ns / 1ps
// Self-checking testbench for symbol_intern_hash_table: sends name bytes, predicts the
// bucket and status of every interned name and checks each result transfer in order.
// Depends on sith_pkg, sith_in_if, sith_out_if and the block itself.
module tb_symbol_intern_hash_table;
    import sith_pkg::*;

    localparam int MAX_TEST_LEN  = 64;    // longest name the stimulus ever sends
    localparam int HISTORY_DEPTH = 256;   // names remembered for repeated look-ups
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 300;   // quiet period once every result has arrived
    localparam int HOLD_OFF_LEN  = 400;   // long receiver hold-off in the pressure test

    typedef struct packed {
        logic [IDX_W-1:0] bucket;
        status_t          status;
    } intern_result_t;

    logic clk = 1'b0;
    logic rst_n;

    sith_in_if  names ();
    sith_out_if results ();

    symbol_intern_hash_table DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .names   (names),
        .results (results)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predicted state of the symbol table. It is advanced on every accepted
    // byte transfer, so it always reflects exactly what the block has taken.
    // ------------------------------------------------------------------
    logic [HASH_W-1:0] name_hash;
    logic [BYTE_W-1:0] name_buf [MAX_NAME_LEN];
    int unsigned       name_count;
    bit                name_overflow;
    logic [BYTE_W-1:0] bucket_bytes [TABLE_SIZE][MAX_NAME_LEN];
    int unsigned       bucket_len [TABLE_SIZE];
    intern_result_t    awaited_results [$];

    // Stimulus state: the name being sent and a ring of names sent earlier.
    logic [BYTE_W-1:0] tx_name [MAX_TEST_LEN];
    int                tx_len;
    logic [BYTE_W-1:0] sent_names [HISTORY_DEPTH][MAX_TEST_LEN];
    int                sent_len [HISTORY_DEPTH];
    int unsigned       sent_count = 0;

    // For three-byte names the home bucket moves by a fixed step per unit of the
    // last byte, so this maps a wanted bucket offset back to that last byte.
    int                last_byte_for_offset [TABLE_SIZE];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_off_left  = 0;
    int unsigned mismatches     = 0;

    // One step of the PJW hash: shift in a byte, then fold any bits that reached
    // the top nibble back into bits 7:4 and clear them from the top.
    function automatic logic [HASH_W-1:0] pjw_step(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] c);
        logic [HASH_W-1:0] s;
        s = {h[HASH_W-5:0], 4'h0} + {24'h0, c};
        if (s[31:28] != 4'h0)
        begin
            s = s ^ {s[31:28], 20'h0, s[31:28], 4'h0};
        end
        return s;
    endfunction

    // Home bucket of a three-byte name; the final byte is hashed twice.
    function automatic int unsigned home_bucket3(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic [BYTE_W-1:0] c);
        logic [HASH_W-1:0] h;
        h = pjw_step(pjw_step(pjw_step(pjw_step('0, a), b), c), c);
        return h % 32'(TABLE_SIZE);
    endfunction

    // Advances the predicted table by one accepted byte. The final byte of a
    // name produces exactly one expected result.
    task automatic predict_transfer(input logic [BYTE_W-1:0] b, input logic is_last);
        intern_result_t res;
        int unsigned    slot;
        bit             settled;
        bit             same;
        if (name_count < MAX_NAME_LEN)
        begin
            name_buf[name_count] = b;
            name_count++;
            name_hash = pjw_step(name_hash, b);
        end
        else
        begin
            name_overflow = 1'b1;
        end

        if (is_last)
        begin
            res.bucket = '0;
            res.status = STAT_TOO_LONG;
            if (!name_overflow)
            begin
                // The final byte goes through the hash a second time before
                // the linear probe starts at the home bucket.
                name_hash  = pjw_step(name_hash, name_buf[name_count - 1]);
                slot       = name_hash % 32'(TABLE_SIZE);
                res.status = STAT_FULL;
                settled    = 1'b0;
                for (int n = 0; n < TABLE_SIZE && !settled; n++)
                begin
                    if (bucket_len[slot] == 0)
                    begin
                        for (int i = 0; i < name_count; i++)
                            bucket_bytes[slot][i] = name_buf[i];
                        bucket_len[slot] = name_count;
                        res.bucket = IDX_W'(slot);
                        res.status = STAT_INSERTED;
                        settled    = 1'b1;
                    end
                    else if (bucket_len[slot] == name_count)
                    begin
                        same = 1'b1;
                        for (int i = 0; i < name_count; i++)
                            if (bucket_bytes[slot][i] != name_buf[i])
                                same = 1'b0;
                        if (same)
                        begin
                            res.bucket = IDX_W'(slot);
                            res.status = STAT_FOUND;
                            settled    = 1'b1;
                        end
                    end
                    if (!settled)
                        slot = (slot == TABLE_SIZE - 1) ? 0 : slot + 1;
                end
                // A full sweep without a match or a free bucket leaves the
                // result at table full with bucket zero.
                if (!settled)
                    res.bucket = '0;
            end
            awaited_results.push_back(res);
            name_hash     = '0;
            name_count    = 0;
            name_overflow = 1'b0;
        end
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s", $time, what);
    endtask

    // Offers one byte, with random idle cycles ahead of it, and waits for the
    // transfer. The valid stays high afterwards so back-to-back bytes need no
    // second assignment within the same step.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            names.valid <= 1'b0;
            @(posedge clk);
        end
        names.valid     <= 1'b1;
        names.name_byte <= b;
        names.last_byte <= is_last;
        @(posedge clk);
        while (!names.ready)
            @(posedge clk);
        predict_transfer(b, is_last);
    endtask

    task automatic send_name();
        int unsigned ring;
        for (int i = 0; i < tx_len; i++)
            send_byte(tx_name[i], i == tx_len - 1);
        ring = sent_count % HISTORY_DEPTH;
        sent_len[ring] = tx_len;
        for (int i = 0; i < tx_len; i++)
            sent_names[ring][i] = tx_name[i];
        sent_count++;
    endtask

    // Drops the valid and waits until every predicted result has been seen.
    task automatic wait_for_results();
        names.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Random content; a quarter of names use a four-letter alphabet so that
    // short names repeat and equal-length near misses are common.
    task automatic randomise_name(input int len);
        bit narrow;
        narrow = ($urandom_range(3) == 0);
        tx_len = len;
        for (int i = 0; i < len; i++)
            tx_name[i] = narrow ? 8'h61 + BYTE_W'($urandom_range(3))
                                : BYTE_W'($urandom_range(255));
    endtask

    task automatic build_random_name();
        int unsigned pick;
        int unsigned held;
        int unsigned src;
        pick = $urandom_range(99);
        held = (sent_count < HISTORY_DEPTH) ? sent_count : HISTORY_DEPTH;
        if (pick < 25 && held != 0)
        begin
            // Repeat an earlier name, which should now be found.
            src    = $urandom_range(held - 1);
            tx_len = sent_len[src];
            for (int i = 0; i < tx_len; i++)
                tx_name[i] = sent_names[src][i];
        end
        else if (pick < 32)
            randomise_name($urandom_range(MAX_TEST_LEN, MAX_NAME_LEN + 1));
        else if (pick < 37)
            randomise_name(MAX_NAME_LEN);
        else if (pick < 85)
            randomise_name($urandom_range(6, 1));
        else
            randomise_name($urandom_range(MAX_NAME_LEN - 1, 7));
    endtask

    // Loads a three-byte name whose home bucket is the given one. The first two
    // bytes are random; the last is solved for and the result confirmed.
    task automatic load_name_homed_at(input int unsigned target);
        int unsigned base;
        int          solved;
        bit          hit;
        hit = 1'b0;
        while (!hit)
        begin
            tx_name[0] = BYTE_W'($urandom_range(255));
            tx_name[1] = BYTE_W'($urandom_range(255));
            base   = home_bucket3(tx_name[0], tx_name[1], 8'h00);
            solved = last_byte_for_offset[(target + TABLE_SIZE - base) % TABLE_SIZE];
            if (solved >= 0)
            begin
                tx_name[2] = solved[7:0];
                hit = (home_bucket3(tx_name[0], tx_name[1], tx_name[2]) == target);
            end
        end
        tx_len = 3;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Single-byte extremes, a repeat, two different names that share a home
    // bucket (so the probe must step past occupied buckets) and a name long
    // enough for the hash to fold its top nibble.
    task automatic test_directed_names();
        logic [BYTE_W-1:0] first [3];
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        tx_len = 1;
        tx_name[0] = 8'h00;
        send_name();
        tx_name[0] = 8'hFF;
        send_name();
        tx_name[0] = 8'h00;
        send_name();
        // A lone zero byte hashes to zero, so both of these start at bucket 0.
        load_name_homed_at(0);
        for (int i = 0; i < 3; i++)
            first[i] = tx_name[i];
        send_name();
        do
            load_name_homed_at(0);
        while (tx_name[0] == first[0] && tx_name[1] == first[1] && tx_name[2] == first[2]);
        send_name();
        send_name();
        tx_len = 9;
        for (int i = 0; i < tx_len; i++)
            tx_name[i] = 8'hFF;
        send_name();
        wait_for_results();
    endtask

    // Names of exactly the maximum length, one byte over it (sharing its
    // first bytes with a stored name), and far over it.
    task automatic test_length_limits();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        randomise_name(MAX_NAME_LEN);
        send_name();
        send_name();
        tx_name[MAX_NAME_LEN] = BYTE_W'($urandom_range(255));
        tx_len = MAX_NAME_LEN + 1;
        send_name();
        randomise_name(MAX_TEST_LEN);
        send_name();
        tx_len = MAX_NAME_LEN;
        for (int i = 0; i < tx_len; i++)
            tx_name[i] = 8'hFF;
        send_name();
        wait_for_results();
    endtask

    task automatic test_random_names(input int unsigned byte_budget,
                                     input int unsigned idle_pct,
                                     input int unsigned stall_pct);
        int unsigned sent_bytes;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent_bytes     = 0;
        while (sent_bytes < byte_budget)
        begin
            build_random_name();
            send_name();
            sent_bytes += tx_len;
        end
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while names keep coming, so the
    // block must stall its input; after a full drain more names follow with random stalls.
    task automatic test_back_pressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = HOLD_OFF_LEN;
        repeat (24)
        begin
            randomise_name($urandom_range(4, 1));
            send_name();
        end
        wait_for_results();
        send_idle_pct  = 50;
        recv_stall_pct = 50;
        repeat (6)
        begin
            build_random_name();
            send_name();
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Result side: ready pattern and checking
    // ------------------------------------------------------------------

    // Ready is held low for any requested hold-off, otherwise stalls at random.
    always @(posedge clk)
    begin
        if (hold_off_left != 0)
        begin
            results.ready <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end
        else
        begin
            results.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every result transfer is compared with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        intern_result_t want;
        if (rst_n && results.valid && results.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result: bucket %0d status %0d",
                                        results.bucket_index, results.status));
            end
            else
            begin
                want = awaited_results.pop_front();
                if (results.bucket_index !== want.bucket || results.status !== want.status)
                    note_mismatch($sformatf(
                        "result mismatch: expected bucket %0d status %s, got bucket %0d status %0d",
                        want.bucket, want.status.name(), results.bucket_index, results.status));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned r;
        names.valid     = 1'b0;
        names.name_byte = '0;
        names.last_byte = 1'b0;
        results.ready   = 1'b0;
        rst_n           = 1'b0;

        name_hash     = '0;
        name_count    = 0;
        name_overflow = 1'b0;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            bucket_len[i]           = 0;
            last_byte_for_offset[i] = -1;
        end
        // Names 00 00 c hash to offsets from bucket 0; record which c gives which.
        for (int c = 0; c < 256; c++)
        begin
            r = home_bucket3(8'h00, 8'h00, BYTE_W'(c));
            last_byte_for_offset[r] = c;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The block clears its bucket store after reset with its input held
        // off; the first transfer simply waits for that to finish.
        test_directed_names();
        test_length_limits();
        test_random_names(240, 0, 0);
        test_random_names(240, 69, 0);
        test_random_names(240, 0, 69);
        test_random_names(240, 37, 37);
        test_back_pressure();

        // Anything arriving now is a result nobody asked for.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("** symbol_intern_hash_table: PASSED **");
        else
            $display("** symbol_intern_hash_table: FAILED **");
        $finish;
    end

    // Watchdog: a run that is still going at this point counts as failed.
    initial
    begin
        #20_000_000;
        $display("** symbol_intern_hash_table: FAILED **");
        $finish;
    end

endmodule
